// ===== rtl/lzw_pkg.sv =====
// Package: shared types and constants for the LZW byte encoder.
package lzw_pkg;
  localparam int DictSizeDefault = 4096;
  localparam int RootCodes = 256;
  localparam int CodeW = 12;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } lzw_in_t;

  typedef struct packed {
    logic [CodeW-1:0] out_code;
    logic             last_of_stream;
  } lzw_out_t;
endpackage

// ===== rtl/lzw_byte_encoder.sv =====
// Top level: LZW byte encoder with a trie dictionary held in block memory.
//
// Usage: bytes arrive as requests on the in_ channel (valid/stall); codes leave
// on the out_ channel (valid/stall). Each code carries last_of_stream, set
// only on the flushed code of the byte marked end_of_data.
// A byte causes zero, one or two codes. One byte is handled at a time.
// Per byte: after the accept, the first-child link of the current string is
// read and checked, then each child on the sibling list is read and checked.
// A miss ends at a string with no children or at the list tail; it adds an
// emit step and, while the dictionary has room, an insert that first links
// the parent or the tail and then writes the new entry. The first byte of a
// stream only sets the current string. The code of the last string is flushed.
// Emitted codes pass through a single output register; when the receiver
// stalls, the engine holds in its emit or flush state until the code is taken.
// After the final byte, the first-child links are reset by a clearing pass
// over the whole dictionary, one entry per cycle. The same pass runs after
// reset before the first byte is taken.
// The suffix and sibling memories are never cleared: every link that is
// followed points at an entry written earlier in the same stream.
module lzw_byte_encoder
  import lzw_pkg::*;
#(
  parameter int DICT_SIZE = DictSizeDefault
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  lzw_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output lzw_out_t out_data
);
  localparam int AW = $clog2(DICT_SIZE);
  localparam int LW = AW + 1;                 // link: MSB set means none
  localparam logic [LW-1:0] LinkNone = {1'b1, {AW{1'b0}}};

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_FCRD   = 4'd2;     // first-child read in flight
  localparam logic [3:0] S_FCCHK  = 4'd3;
  localparam logic [3:0] S_NODERD = 4'd4;     // suffix/sibling read in flight
  localparam logic [3:0] S_NODECK = 4'd5;
  localparam logic [3:0] S_EMIT   = 4'd6;     // miss code out
  localparam logic [3:0] S_INSERT = 4'd7;
  localparam logic [3:0] S_FLUSH  = 4'd8;

  // Memories.
  logic [7:0]    suf_mem [DICT_SIZE];
  logic [LW-1:0] fc_mem  [DICT_SIZE];
  logic [LW-1:0] sib_mem [DICT_SIZE];

  logic [AW-1:0] rd_addr;
  logic [7:0]    suf_q_r;
  logic [LW-1:0] fc_q_r, sib_q_r;

  logic          fc_we, sib_we, suf_we;
  logic [AW-1:0] fc_wa, sib_wa, suf_wa;
  logic [LW-1:0] fc_wd, sib_wd;

  logic [3:0]    state_r, state_nxt;
  logic [AW:0]   clr_cnt_r, clr_cnt_nxt;
  logic [AW:0]   free_r, free_nxt;          // next free code, can equal DICT_SIZE
  logic [AW-1:0] cur_r, cur_nxt;
  logic          cur_vld_r, cur_vld_nxt;
  logic [7:0]    in_byte_r, in_byte_nxt;
  logic          in_last_r, in_last_nxt;
  logic [AW-1:0] node_r, node_nxt;
  logic          ins_r, ins_nxt;              // walking to the tail for insert
  logic          out_valid_r, out_valid_nxt;
  lzw_out_t      out_data_r, out_data_nxt;

  always_ff @(posedge clk) begin
    if (fc_we) fc_mem[fc_wa] <= fc_wd;
    if (sib_we) sib_mem[sib_wa] <= sib_wd;
    if (suf_we) suf_mem[suf_wa] <= in_byte_r;
    fc_q_r  <= fc_mem[rd_addr];
    sib_q_r <= sib_mem[rd_addr];
    suf_q_r <= suf_mem[rd_addr];
  end

  wire out_free = !out_valid_r || !out_stall;
  wire in_acc   = in_valid && (state_r == S_IDLE);
  wire dict_room = free_r < (AW+1)'(DICT_SIZE);

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    free_nxt      = free_r;
    cur_nxt       = cur_r;
    cur_vld_nxt   = cur_vld_r;
    in_byte_nxt   = in_byte_r;
    in_last_nxt   = in_last_r;
    node_nxt      = node_r;
    ins_nxt       = ins_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    rd_addr       = cur_r;
    fc_we = 1'b0; fc_wa = cur_r; fc_wd = LinkNone;
    sib_we = 1'b0; sib_wa = node_r; sib_wd = LinkNone;
    suf_we = 1'b0; suf_wa = free_r[AW-1:0];
    case (state_r)
      S_CLEAR: begin
        fc_we = 1'b1;
        fc_wa = clr_cnt_r[AW-1:0];
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == (AW+1)'(DICT_SIZE - 1)) begin
          state_nxt = S_IDLE;
          clr_cnt_nxt = '0;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          in_byte_nxt = in_data.data_byte;
          in_last_nxt = in_data.end_of_data;
          ins_nxt = 1'b0;
          if (!cur_vld_r) begin
            cur_nxt = AW'(in_data.data_byte);
            cur_vld_nxt = 1'b1;
            state_nxt = in_data.end_of_data ? S_FLUSH : S_IDLE;
          end else begin
            state_nxt = S_FCRD;
          end
        end
      end
      S_FCRD: state_nxt = S_FCCHK;
      S_FCCHK: begin
        if (fc_q_r[AW]) begin
          // no children: miss, insert as first child; park node off the
          // free code so the insert links the parent first
          node_nxt = ~free_r[AW-1:0];
          state_nxt = S_EMIT;
        end else begin
          node_nxt = fc_q_r[AW-1:0];
          rd_addr = fc_q_r[AW-1:0];
          state_nxt = S_NODERD;
        end
      end
      S_NODERD: begin
        rd_addr = node_r;
        state_nxt = S_NODECK;
      end
      S_NODECK: begin
        rd_addr = sib_q_r[AW-1:0];
        if (ins_r) begin
          if (sib_q_r[AW]) state_nxt = S_INSERT;
          else begin node_nxt = sib_q_r[AW-1:0]; state_nxt = S_NODERD; end
        end else if (suf_q_r == in_byte_r) begin
          cur_nxt = node_r;
          state_nxt = in_last_r ? S_FLUSH : S_IDLE;
        end else if (sib_q_r[AW]) begin
          ins_nxt = 1'b1;
          state_nxt = S_EMIT;     // miss; node_r is the tail already
        end else begin
          node_nxt = sib_q_r[AW-1:0];
          state_nxt = S_NODERD;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.out_code = CodeW'(cur_r);
          out_data_nxt.last_of_stream = 1'b0;
          if (dict_room) state_nxt = S_INSERT;
          else begin
            cur_nxt = AW'(in_byte_r);
            state_nxt = in_last_r ? S_FLUSH : S_IDLE;
          end
        end
      end
      S_INSERT: begin
        // new entry: suffix, no child, no sibling; hook to parent or tail
        suf_we = 1'b1;
        sib_we = 1'b1;
        sib_wa = free_r[AW-1:0];
        fc_we = 1'b1;
        fc_wa = free_r[AW-1:0];
        state_nxt = S_IDLE;
        free_nxt = free_r + 1'b1;
        cur_nxt = AW'(in_byte_r);
        if (in_last_r) state_nxt = S_FLUSH;
        ins_nxt = 1'b0;
        if (ins_r) begin
          // second port of sibling memory not available: link tail first
          sib_wa = node_r;
          sib_wd = {1'b0, free_r[AW-1:0]};
          suf_we = 1'b0;
          fc_we = 1'b0;
          free_nxt = free_r;
          cur_nxt = cur_r;
          node_nxt = free_r[AW-1:0];
          state_nxt = S_INSERT;
          ins_nxt = 1'b0;
          in_byte_nxt = in_byte_r;
          // mark done with tail link via node==free
        end else if (node_r != free_r[AW-1:0]) begin
          // first child of the parent: link parent, then write entry
          fc_wa = cur_r;
          fc_wd = {1'b0, free_r[AW-1:0]};
          sib_we = 1'b0;
          suf_we = 1'b0;
          free_nxt = free_r;
          cur_nxt = cur_r;
          node_nxt = free_r[AW-1:0];
          state_nxt = S_INSERT;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.out_code = CodeW'(cur_r);
          out_data_nxt.last_of_stream = 1'b1;
          cur_vld_nxt = 1'b0;
          free_nxt = (AW+1)'(RootCodes);
          clr_cnt_nxt = '0;
          state_nxt = S_CLEAR;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      free_r      <= (AW+1)'(RootCodes);
      cur_vld_r   <= 1'b0;
      ins_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      free_r      <= free_nxt;
      cur_vld_r   <= cur_vld_nxt;
      ins_r       <= ins_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    in_byte_r  <= in_byte_nxt;
    in_last_r  <= in_last_nxt;
    node_r     <= node_nxt;
    out_data_r <= out_data_nxt;
  end

  // A held code must not change while the receiver stalls.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output changed under stall");
  // The dictionary never grows past its size.
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= (AW+1)'(DICT_SIZE))
    else $error("free code overflow");
  // A flushed last code returns the engine to the clearing pass.
  a_flush_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FLUSH) && out_free |=> (state_r == S_CLEAR) && !cur_vld_r)
    else $error("flush did not reset dictionary");
endmodule
